// File: design/dtr_pkg.sv
package dtr_pkg;

    // Item kinds carried on the input tuser bit
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SAVE_DELAY = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOOT       = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ON_LEVEL   = 2'd3;

    // Register widths and reset values
    localparam int CFG_DATA_W  = 16;
    localparam int TICKS_W     = 16;
    localparam logic [TICKS_W-1:0] DEBOUNCE_RST   = 16'd50;
    localparam logic [TICKS_W-1:0] SAVE_DELAY_RST = 16'd2000;
    localparam logic               ON_LEVEL_RST   = 1'b1;

endpackage

// File: design/debounced_toggle_relay_with_delayed_save.sv
// Debounced toggle relays with deferred save. Tick beats (tuser = 0) carry one
// sampled wall-switch level per device; a level that has held for
// debounce_ticks ticks and differs from the last stable level toggles that
// device's relay. Set beats (tuser = 1) force one relay on or off. A relay
// that really changes turns dirty, and once its save age reaches
// save_delay_ticks a later tick reports it in save_mask if it differs from the
// last saved copy. The first tick after reset only primes the switch levels
// and loads boot_states. Every input beat yields exactly one output beat.
// Rate: one beat per cycle while m_tready holds; each beat passes the update stage and then the output register. The
// whole per-device state sits in one row of a synchronous RAM; each beat reads
// the row, updates it and writes it back, and the write of the previous beat
// is forwarded to the next one so back-to-back beats see current state.
// Configuration goes through the plain write port; write it only while idle, as the block does not enforce this.
module debounced_toggle_relay_with_delayed_save #(
    parameter int DEVICES   = 2,
    parameter int AGE_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,

    // slave side; s_tdata from bit 0: switch_levels, dev_index, set_on
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((DEVICES + 2 + 7) / 8) * 8-1:0] s_tdata,
    input  logic                                 s_tuser,   // cmd

    // master side; m_tdata from bit 0: relay_states, relay_pins,
    // state_changed, save_mask, save_values
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((4 * DEVICES + 1 + 7) / 8) * 8-1:0] m_tdata,

    input  logic                             cfg_wr_en,
    input  logic [dtr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dtr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int ROW_W   = 1 + 5 * DEVICES + 2 * DEVICES * AGE_WIDTH;
    localparam int OUT_W   = 4 * DEVICES + 1;
    localparam int OUT_TW  = ((OUT_W + 7) / 8) * 8;

    // Configuration registers
    logic [dtr_pkg::TICKS_W-1:0] debounce_reg;
    logic [dtr_pkg::TICKS_W-1:0] save_delay_reg;
    logic [DEVICES-1:0]          boot_reg;
    logic                        on_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= dtr_pkg::DEBOUNCE_RST;
            save_delay_reg <= dtr_pkg::SAVE_DELAY_RST;
            boot_reg       <= '0;
            on_level_reg   <= dtr_pkg::ON_LEVEL_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                dtr_pkg::CFG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                dtr_pkg::CFG_SAVE_DELAY: save_delay_reg <= cfg_wdata;
                dtr_pkg::CFG_BOOT:       boot_reg       <= cfg_wdata[DEVICES-1:0];
                dtr_pkg::CFG_ON_LEVEL:   on_level_reg   <= cfg_wdata[0];
                default:                 ;
            endcase
        end
    end

    // Update stage: holds the accepted beat while its state row arrives
    logic               s1_valid_reg;
    logic               s1_cmd_reg;
    logic [DEVICES-1:0] s1_levels_reg;
    logic               s1_idx_reg;
    logic               s1_on_reg;
    logic               s1_adv;
    logic               in_acc;

    // Output register
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    // State RAM and forwarding
    logic              mem_valid_reg;   // row written at least once since reset
    logic              rd_valid_reg;
    logic              fwd_sel_reg;
    logic [ROW_W-1:0]  fwd_data_reg;
    logic [ROW_W-1:0]  ram_q;
    logic [ROW_W-1:0]  row_cur;
    logic [ROW_W-1:0]  row_new;

    logic [DEVICES-1:0] relay_states;
    logic               state_changed;
    logic [DEVICES-1:0] save_mask;
    logic [OUT_W-1:0]   result;

    // Advance when the output slot is free or being emptied this cycle
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg    <= s_tuser;
            s1_levels_reg <= s_tdata[DEVICES-1:0];
            s1_idx_reg    <= s_tdata[DEVICES];
            s1_on_reg     <= s_tdata[DEVICES+1];
        end
    end

    dtr_ram #(
        .WIDTH (ROW_W),
        .DEPTH (1)
    ) u_state_ram (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (1'b0),
        .wdata (row_new),
        .re    (in_acc),
        .raddr (1'b0),
        .rdata (ram_q)
    );

    // Capture, at the read edge, whether the RAM data is stale or unwritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= 1'b0;
            rd_valid_reg  <= 1'b0;
            fwd_sel_reg   <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                mem_valid_reg <= 1'b1;
            end
            if (in_acc)
            begin
                rd_valid_reg <= mem_valid_reg;
                fwd_sel_reg  <= s1_adv;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && s1_adv)
        begin
            fwd_data_reg <= row_new;
        end
    end

    // Unwritten row reads as the reset state, all zeros
    assign row_cur = fwd_sel_reg  ? fwd_data_reg :
                     rd_valid_reg ? ram_q        : '0;

    dtr_update #(
        .DEVICES   (DEVICES),
        .AGE_WIDTH (AGE_WIDTH),
        .ROW_W     (ROW_W)
    ) u_update (
        .row_in           (row_cur),
        .cmd              (s1_cmd_reg),
        .levels           (s1_levels_reg),
        .dev_index        (s1_idx_reg),
        .set_on           (s1_on_reg),
        .debounce_ticks   (debounce_reg),
        .save_delay_ticks (save_delay_reg),
        .boot_states      (boot_reg),
        .row_out          (row_new),
        .relay_states     (relay_states),
        .state_changed    (state_changed),
        .save_mask        (save_mask)
    );

    assign result = {relay_states & save_mask,
                     save_mask,
                     state_changed,
                     relay_states ^ {DEVICES{~on_level_reg}},
                     relay_states};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TW'(out_data_reg);

    // Every write-back leaves a result waiting on the master side
    a_wb_loads_result : assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> m_tvalid)
        else $error("write-back without a result");

    // A busy update stage never blocks intake while the output drains
    a_no_bubble : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && m_tready) |-> s_tready)
        else $error("intake stalled with output draining");

    // Set beats never report a save
    a_set_no_save : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_cmd_reg == dtr_pkg::CMD_SET)) |=>
        (out_data_reg[2*DEVICES+1 +: DEVICES] == '0))
        else $error("save reported on a set beat");

    // A write-back at the read edge always selects the forwarded row
    a_fwd_after_wb : assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s1_adv) |=> fwd_sel_reg)
        else $error("forwarding missed a same-edge write-back");

endmodule

// File: design/dtr_ram.sv
module dtr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/dtr_update.sv
module dtr_update #(
    parameter int DEVICES   = 2,
    parameter int AGE_WIDTH = 16,
    parameter int ROW_W     = 1 + 5 * DEVICES + 2 * DEVICES * AGE_WIDTH
) (
    input  logic [ROW_W-1:0]             row_in,
    input  logic                         cmd,
    input  logic [DEVICES-1:0]           levels,
    input  logic                         dev_index,
    input  logic                         set_on,
    input  logic [dtr_pkg::TICKS_W-1:0]  debounce_ticks,
    input  logic [dtr_pkg::TICKS_W-1:0]  save_delay_ticks,
    input  logic [DEVICES-1:0]           boot_states,
    output logic [ROW_W-1:0]             row_out,
    output logic [DEVICES-1:0]           relay_states,
    output logic                         state_changed,
    output logic [DEVICES-1:0]           save_mask
);

    localparam int CMP_W = (AGE_WIDTH > dtr_pkg::TICKS_W) ? AGE_WIDTH : dtr_pkg::TICKS_W;

    typedef struct packed {
        logic                               primed;
        logic [DEVICES-1:0]                 relay;
        logic [DEVICES-1:0]                 saved;
        logic [DEVICES-1:0]                 dirty;
        logic [DEVICES-1:0]                 raw;
        logic [DEVICES-1:0]                 stable;
        logic [DEVICES-1:0][AGE_WIDTH-1:0]  edge_age;
        logic [DEVICES-1:0][AGE_WIDTH-1:0]  dirty_age;
    } row_t;

    row_t cur;
    row_t nxt;
    logic [DEVICES-1:0] smask;

    assign cur = row_t'(row_in);

    assign nxt.primed = cur.primed | (cmd == dtr_pkg::CMD_TICK);

    for (genvar d = 0; d < DEVICES; d++)
    begin : g_dev
        logic [AGE_WIDTH-1:0] ea_inc;
        logic [AGE_WIDTH-1:0] da_inc;
        logic                 hit;

        assign ea_inc = (&cur.edge_age[d]) ? cur.edge_age[d] : cur.edge_age[d] + 1'b1;
        assign da_inc = (&cur.dirty_age[d]) ? cur.dirty_age[d] : cur.dirty_age[d] + 1'b1;
        assign hit    = (32'(dev_index) == d);

        always_comb
        begin
            logic r;
            logic dt;
            logic [AGE_WIDTH-1:0] da;

            nxt.relay[d]     = cur.relay[d];
            nxt.saved[d]     = cur.saved[d];
            nxt.dirty[d]     = cur.dirty[d];
            nxt.raw[d]       = cur.raw[d];
            nxt.stable[d]    = cur.stable[d];
            nxt.edge_age[d]  = cur.edge_age[d];
            nxt.dirty_age[d] = cur.dirty_age[d];
            smask[d]         = 1'b0;
            r  = cur.relay[d];
            dt = cur.dirty[d];
            da = da_inc;

            if (cmd == dtr_pkg::CMD_SET)
            begin
                if (hit && (cur.relay[d] != set_on))
                begin
                    nxt.relay[d]     = set_on;
                    nxt.dirty[d]     = 1'b1;
                    nxt.dirty_age[d] = '0;
                end
            end
            else if (!cur.primed)
            begin
                nxt.raw[d]      = levels[d];
                nxt.stable[d]   = levels[d];
                nxt.relay[d]    = boot_states[d];
                nxt.saved[d]    = boot_states[d];
                nxt.dirty[d]    = 1'b0;
                nxt.edge_age[d] = '0;
            end
            else
            begin
                // Debounce: a raw change restarts the edge age
                if (levels[d] != cur.raw[d])
                begin
                    nxt.raw[d]      = levels[d];
                    nxt.edge_age[d] = '0;
                end
                else
                begin
                    nxt.edge_age[d] = ea_inc;
                    if ((CMP_W'(ea_inc) >= CMP_W'(debounce_ticks)) &&
                        (levels[d] != cur.stable[d]))
                    begin
                        nxt.stable[d] = levels[d];
                        r  = ~cur.relay[d];
                        dt = 1'b1;
                        da = '0;
                    end
                end
                // Deferred save of a settled dirty device
                if (dt && (CMP_W'(da) >= CMP_W'(save_delay_ticks)))
                begin
                    if (r != cur.saved[d])
                    begin
                        smask[d]     = 1'b1;
                        nxt.saved[d] = r;
                    end
                    dt = 1'b0;
                end
                nxt.relay[d]     = r;
                nxt.dirty[d]     = dt;
                nxt.dirty_age[d] = da;
            end
        end
    end

    assign row_out       = ROW_W'(nxt);
    assign relay_states  = nxt.relay;
    assign save_mask     = smask;
    assign state_changed = ((cmd == dtr_pkg::CMD_SET) || cur.primed) &&
                           (nxt.relay != cur.relay);

endmodule
